// ----- rtl/lfi_pkg.sv -----
`default_nettype none

package lfi_pkg;

	localparam int DEF_COUNT_BITS      = 16;
	localparam int DEF_COS_TABLE_DEPTH = 256;

	// fixed widths of the ports
	localparam int COUNT_W = 16;
	localparam int LEVEL_W = 8;

	// progress is unsigned Q0.16 plus one bit so that 1.0 is exact
	localparam int PROG_W = 17;
	localparam int DIFF_W = LEVEL_W + 1;
	localparam int PROD_W = DIFF_W + PROG_W + 1;

	localparam logic [PROG_W-1:0] ONE_Q16 = PROG_W'(65536);

	localparam logic [1:0] KIND_RAMP   = 2'd0;
	localparam logic [1:0] KIND_COSINE = 2'd1;
	localparam logic [1:0] KIND_NONE   = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam int          TAYLOR_TERMS = 9;

	typedef struct packed {
		logic [1:0]         kind;
		logic               cnt_zero;
		logic [LEVEL_W-1:0] start_level;
		logic [LEVEL_W-1:0] end_level;
	} lfi_side_t;

	// term divided by (2n-1)(2n)
	function automatic logic [63:0] taylor_div(input int n, input logic [63:0] t);
		case (n)
			1:       return t / 64'd2;
			2:       return t / 64'd12;
			3:       return t / 64'd30;
			4:       return t / 64'd56;
			5:       return t / 64'd90;
			6:       return t / 64'd132;
			7:       return t / 64'd182;
			8:       return t / 64'd240;
			9:       return t / 64'd306;
			default: return t;
		endcase
	endfunction

	// cos(pi/2 * k / 2**aw) in Q16, evaluated at elaboration only
	function automatic logic [PROG_W-1:0] quarter_cos(input int k, input int aw);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] res;
		longint      sum;
		int          n;
		x    = (HALF_PI_Q30 * 64'(k)) >> aw;
		x2   = (x * x) >> 30;
		term = ONE_Q30;
		sum  = longint'(term);
		for (n = 1; n <= TAYLOR_TERMS; n++) begin
			term = taylor_div(n, (term * x2) >> 30);
			if (n[0])
				sum = sum - longint'(term);
			else
				sum = sum + longint'(term);
		end
		if (sum < 0)
			sum = 0;
		res = (64'(sum) + 64'd8192) >> 14;
		if (res > 64'(ONE_Q16))
			res = 64'(ONE_Q16);
		return res[PROG_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/lfi_divider.sv -----
`default_nettype none

// restoring divider, one quotient bit per stage: quo = idx * 2**16 / cnt, idx <= cnt
module lfi_divider import lfi_pkg::*; #(
	parameter int CW = DEF_COUNT_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [CW-1:0]   cnt,
	input  logic [CW-1:0]   idx,
	input  lfi_side_t       side_in,
	output logic            out_vld,
	output logic [PROG_W-1:0] quo,
	output lfi_side_t       side_out
);

	logic              vld_s  [PROG_W];
	logic [CW-1:0]     rem_s  [PROG_W];
	logic [CW-1:0]     cnt_s  [PROG_W];
	logic [PROG_W-1:0] quo_s  [PROG_W];
	lfi_side_t         side_s [PROG_W];

	for (genvar k = 0; k < PROG_W; k++) begin : g_step
		logic              pv;
		logic [CW-1:0]     pcnt;
		logic [PROG_W-1:0] pquo;
		lfi_side_t         pside;
		logic [CW:0]       trial;
		logic [CW:0]       diff;
		logic              ge;

		if (k == 0) begin : g_first
			// integer bit: no shift before the first compare
			assign pv    = in_vld;
			assign pcnt  = cnt;
			assign pquo  = '0;
			assign pside = side_in;
			assign trial = {1'b0, idx};
		end else begin : g_next
			assign pv    = vld_s[k-1];
			assign pcnt  = cnt_s[k-1];
			assign pquo  = quo_s[k-1];
			assign pside = side_s[k-1];
			assign trial = {rem_s[k-1], 1'b0};
		end

		assign ge   = (trial >= {1'b0, pcnt});
		assign diff = trial - {1'b0, pcnt};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= pv;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[CW-1:0] : trial[CW-1:0];
				cnt_s[k]  <= pcnt;
				quo_s[k]  <= {pquo[PROG_W-2:0], ge};
				side_s[k] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[PROG_W-1];
	assign quo      = quo_s[PROG_W-1];
	assign side_out = side_s[PROG_W-1];

endmodule

`default_nettype wire

// ----- rtl/lfi_cos_rom.sv -----
`default_nettype none

// quarter-wave cosine table, DEPTH+1 entries, registered read
module lfi_cos_rom import lfi_pkg::*; #(
	parameter int DEPTH = DEF_COS_TABLE_DEPTH
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [$clog2(DEPTH):0]     addr,
	output logic [PROG_W-1:0]          rdata
);

	localparam int AW = $clog2(DEPTH);

	logic [PROG_W-1:0] rom [DEPTH+1];
	logic [PROG_W-1:0] rdata_q;

	for (genvar k = 0; k <= DEPTH; k++) begin : g_rom
		localparam logic [PROG_W-1:0] QV = quarter_cos(k, AW);
		assign rom[k] = QV;
	end

	always_ff @(posedge clk) begin
		if (en)
			rdata_q <= rom[addr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/lfi_blend.sv -----
`default_nettype none

// progress select, multiply and final level with the special cases
module lfi_blend import lfi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_vld,
	input  logic [PROG_W-1:0]  quo,
	input  logic               neg,
	input  logic [PROG_W-1:0]  cos_val,
	input  lfi_side_t          side_in,
	output logic               out_vld,
	output logic [LEVEL_W-1:0] level
);

	logic [PROG_W:0]          cos_sum;
	logic [PROG_W-1:0]        prog_raw;
	logic [PROG_W-1:0]        prog;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] num;
	logic [LEVEL_W-1:0]       level_d;

	logic                     vld_s21, vld_s22, vld_s23;
	logic [PROG_W-1:0]        prog_s21;
	logic signed [DIFF_W-1:0] diff_s21;
	lfi_side_t                side_s21, side_s22;
	logic signed [PROD_W-1:0] prod_s22;
	logic [LEVEL_W-1:0]       level_s23;

	// (1 -/+ c) / 2, c negative in the second half of the curve
	assign cos_sum  = neg ? ({1'b0, ONE_Q16} + {1'b0, cos_val})
	                      : ({1'b0, ONE_Q16} - {1'b0, cos_val});
	assign prog_raw = (side_in.kind == KIND_RAMP) ? quo : cos_sum[PROG_W:1];
	assign prog     = (prog_raw > ONE_Q16) ? ONE_Q16 : prog_raw;
	assign diff     = $signed({1'b0, side_in.end_level}) - $signed({1'b0, side_in.start_level});

	assign num = $signed({3'b000, side_s22.start_level, 16'h0000}) + prod_s22;

	always_comb begin
		if (side_s22.kind == KIND_NONE || side_s22.kind == KIND_RSVD)
			level_d = '0;
		else if (side_s22.cnt_zero)
			level_d = side_s22.end_level;
		else if (num < 0)
			level_d = '0;
		else
			level_d = num[16 +: LEVEL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s21 <= 1'b0;
			vld_s22 <= 1'b0;
			vld_s23 <= 1'b0;
		end else if (en) begin
			vld_s21 <= in_vld;
			vld_s22 <= vld_s21;
			vld_s23 <= vld_s22;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prog_s21  <= prog;
			diff_s21  <= diff;
			side_s21  <= side_in;
			prod_s22  <= PROD_W'(diff_s21) * PROD_W'($signed({1'b0, prog_s21}));
			side_s22  <= side_s21;
			level_s23 <= level_d;
		end
	end

	assign out_vld = vld_s23;
	assign level   = level_s23;

endmodule

`default_nettype wire

// ----- rtl/led_fade_interpolator.sv -----
// a transaction accepted while out_stall is low passes the input register, 17 divider stages, table address,
// table read, 3 blend stages and the output register before its result is shown
// throughput: one transaction per cycle while the skid register is empty; the 17-stage pipelined divider sets the depth
// a skid register at the output takes one more result while out_stall is high
// reset: arst_n asynchronous, clears all valid bits; the block is ready right after reset
// COS_TABLE_DEPTH must be a power of two
`default_nettype none

module led_fade_interpolator import lfi_pkg::*; #(
	parameter int COUNT_BITS      = DEF_COUNT_BITS,
	parameter int COS_TABLE_DEPTH = DEF_COS_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         kind,
	input  logic [COUNT_W-1:0] step_count,
	input  logic [COUNT_W-1:0] step_index,
	input  logic [LEVEL_W-1:0] start_level,
	input  logic [LEVEL_W-1:0] end_level,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [LEVEL_W-1:0] level
);

	localparam int CW = (COUNT_BITS < COUNT_W) ? COUNT_BITS : COUNT_W;
	localparam int AW = $clog2(COS_TABLE_DEPTH);
	localparam logic [AW+1:0] DEP  = (AW+2)'(COS_TABLE_DEPTH);
	localparam logic [AW+1:0] SPAN = (AW+2)'(2 * COS_TABLE_DEPTH);

	logic en;

	logic [CW-1:0] cnt_m, idx_m;
	logic          vld_s1;
	logic [CW-1:0] cnt_s1, idx_s1;
	lfi_side_t     side_s1, side_d;

	logic              div_vld;
	logic [PROG_W-1:0] div_quo;
	lfi_side_t         div_side;

	logic [AW+1:0]     pos, mirror;
	logic              vld_s19, neg_s19;
	logic [AW:0]       addr_s19;
	logic [PROG_W-1:0] quo_s19;
	lfi_side_t         side_s19;

	logic              vld_s20, neg_s20;
	logic [PROG_W-1:0] quo_s20;
	lfi_side_t         side_s20;
	logic [PROG_W-1:0] cos_rd;

	logic               blend_vld;
	logic [LEVEL_W-1:0] blend_level;

	logic               out_valid_q, skid_valid_q;
	logic [LEVEL_W-1:0] level_q, skid_level_q;

	// whole pipeline moves together; it holds only while the skid register is full
	assign en       = !skid_valid_q;
	assign in_stall = skid_valid_q;

	assign cnt_m = step_count[CW-1:0];
	assign idx_m = step_index[CW-1:0];

	always_comb begin
		side_d.kind        = kind;
		side_d.cnt_zero    = (cnt_m == '0);
		side_d.start_level = start_level;
		side_d.end_level   = end_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s1  <= cnt_m;
			idx_s1  <= (idx_m > cnt_m) ? cnt_m : idx_m;
			side_s1 <= side_d;
		end
	end

	lfi_divider #(
		.CW (CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s1),
		.cnt      (cnt_s1),
		.idx      (idx_s1),
		.side_in  (side_s1),
		.out_vld  (div_vld),
		.quo      (div_quo),
		.side_out (div_side)
	);

	// table position idx*2*DEPTH/cnt is the top bits of the Q16 quotient
	assign pos    = div_quo[PROG_W-1 -: AW+2];
	assign mirror = SPAN - pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s19 <= 1'b0;
			vld_s20 <= 1'b0;
		end else if (en) begin
			vld_s19 <= div_vld;
			vld_s20 <= vld_s19;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s19  <= (pos > DEP);
			addr_s19 <= (pos > DEP) ? mirror[AW:0] : pos[AW:0];
			quo_s19  <= div_quo;
			side_s19 <= div_side;
			neg_s20  <= neg_s19;
			quo_s20  <= quo_s19;
			side_s20 <= side_s19;
		end
	end

	lfi_cos_rom #(
		.DEPTH (COS_TABLE_DEPTH)
	) u_rom (
		.clk   (clk),
		.en    (en),
		.addr  (addr_s19),
		.rdata (cos_rd)
	);

	lfi_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s20),
		.quo     (quo_s20),
		.neg     (neg_s20),
		.cos_val (cos_rd),
		.side_in (side_s20),
		.out_vld (blend_vld),
		.level   (blend_level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= blend_vld;
			end
		end else if (en && blend_vld) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			level_q <= skid_valid_q ? skid_level_q : blend_level;
		end else if (en && blend_vld) begin
			skid_level_q <= blend_level;
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;

endmodule

`default_nettype wire

// ----- rtl/lfi_checker.sv -----
`default_nettype none

module lfi_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [1:0] kind,
	input wire logic [15:0] step_count,
	input wire logic [15:0] step_index,
	input wire logic [7:0] start_level,
	input wire logic [7:0] end_level,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] level
);

	// a stalled output transaction stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(level))
		else $error("output transaction dropped or changed while stalled");

	// input stall only comes from an output stall in the cycle before
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stalled without output back-pressure");

	// the skid register is filled only behind a full output register
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output is empty");

	// once the output moves the skid register drains
	a_stall_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_stall |=> !in_stall)
		else $error("input stall held after output moved");

	// the input stall holds while the output stays stalled
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && out_stall |=> in_stall)
		else $error("skid register lost its transaction");

endmodule

bind led_fade_interpolator lfi_checker u_lfi_checker (.*);

`default_nettype wire
